@@ rtl/core/crc8fr_pkg.sv @@
// Shared types, constants and the CRC-8 step function of the frame receiver.
`timescale 1ns / 1ps

package crc8fr_pkg;

    // Frame geometry: the last byte of each frame carries the CRC.
    localparam int FRAME_LEN   = 9;
    localparam int PAYLOAD_LEN = FRAME_LEN - 1;
    localparam int CNT_W       = $clog2(FRAME_LEN);
    localparam int IDX_W       = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;

    // CRC-8 Dallas/Maxim, reflected form.
    localparam logic [7:0] CRC_POLY      = 8'h8C;
    localparam logic [7:0] TIMEOUT_RESET = 8'd2;

    // Input request codes.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_DATA    = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last;
    } out_item_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       store_byte;
        logic       reload_timer;
        logic       dec_timer;
        logic       clear_frame;
        logic       post_single;
        logic [1:0] post_status;
        logic       start_emit;
        logic       emit_step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic frame_full;
        logic crc_match;
        logic timer_active;
        logic timer_last;
        logic emit_done;
        logic out_free;
    } dp_sts_t;

    // One byte through the reflected CRC-8, one bit per step.
    function automatic logic [7:0] crc_update(input logic [7:0] crc_in, input logic [7:0] b_in);
        logic [7:0] crc;
        logic [7:0] b;
        logic       mix;
        crc = crc_in;
        b   = b_in;
        for (int k = 0; k < 8; k++)
        begin
            mix = crc[0] ^ b[0];
            crc = crc >> 1;
            b   = b >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

@@ rtl/core/crc8fr_datapath.sv @@
// Datapath of the frame receiver: frame store, CRC, idle timer and output register.
`timescale 1ns / 1ps

module crc8fr_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crc8fr_pkg::in_item_t in_data,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output crc8fr_pkg::out_item_t out_data,
    input  crc8fr_pkg::dp_cmd_t  cmd,
    output crc8fr_pkg::dp_sts_t  sts
);

    localparam logic [crc8fr_pkg::CNT_W-1:0] CNT_FULL =
        crc8fr_pkg::CNT_W'(crc8fr_pkg::PAYLOAD_LEN);
    localparam logic [crc8fr_pkg::IDX_W-1:0] IDX_LAST =
        crc8fr_pkg::IDX_W'(crc8fr_pkg::PAYLOAD_LEN - 1);

    logic [7:0] frame_mem [crc8fr_pkg::PAYLOAD_LEN];
    logic [7:0] rd_data_reg;

    logic [crc8fr_pkg::CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]                   crc_reg, crc_next;
    logic [7:0]                   timer_reg, timer_next;
    logic [7:0]                   timeout_reg, timeout_next;
    logic [crc8fr_pkg::IDX_W-1:0] emit_idx_reg, emit_idx_next;
    logic                         out_valid_reg, out_valid_next;
    crc8fr_pkg::out_item_t        out_item_reg, out_item_next;

    logic                         rd_en;
    logic [crc8fr_pkg::IDX_W-1:0] rd_addr;

    // Status towards the controller.
    always_comb
    begin
        sts.is_tick      = (in_data.req_type == crc8fr_pkg::REQ_TICK);
        sts.frame_full   = (byte_count_reg == CNT_FULL);
        sts.crc_match    = (in_data.rx_byte == crc_reg);
        sts.timer_active = (timer_reg != 8'd0);
        sts.timer_last   = (timer_reg == 8'd1);
        sts.emit_done    = (emit_idx_reg == IDX_LAST);
        sts.out_free     = !out_valid_reg || out_ready;
    end

    // Frame state: count, running CRC and idle timer.
    always_comb
    begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        timer_next      = timer_reg;
        if (cmd.store_byte)
        begin
            byte_count_next = byte_count_reg + 1'b1;
            crc_next        = crc8fr_pkg::crc_update(crc_reg, in_data.rx_byte);
        end
        if (cmd.reload_timer)
        begin
            timer_next = timeout_reg;
        end
        if (cmd.dec_timer)
        begin
            timer_next = timer_reg - 8'd1;
        end
        if (cmd.clear_frame)
        begin
            byte_count_next = '0;
            crc_next        = 8'd0;
            timer_next      = 8'd0;
        end
    end

    // Configuration register.
    always_comb
    begin
        timeout_next = cfg_valid ? cfg_data : timeout_reg;
    end

    // Emission index and read address into the frame store.
    always_comb
    begin
        emit_idx_next = emit_idx_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        if (cmd.start_emit)
        begin
            emit_idx_next = '0;
            rd_en         = 1'b1;
        end
        else if (cmd.emit_step && !sts.emit_done)
        begin
            emit_idx_next = emit_idx_reg + 1'b1;
            rd_en         = 1'b1;
            rd_addr       = emit_idx_reg + 1'b1;
        end
    end

    // Output register: one beat waits here until taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (cmd.post_single)
        begin
            out_valid_next           = 1'b1;
            out_item_next.status     = cmd.post_status;
            out_item_next.data_byte  = 8'd0;
            out_item_next.byte_index = 6'd0;
            out_item_next.last       = 1'b1;
        end
        else if (cmd.emit_step)
        begin
            out_valid_next           = 1'b1;
            out_item_next.status     = crc8fr_pkg::STATUS_DATA;
            out_item_next.data_byte  = rd_data_reg;
            out_item_next.byte_index = 6'(emit_idx_reg);
            out_item_next.last       = sts.emit_done;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= 8'd0;
            timer_reg      <= 8'd0;
            timeout_reg    <= crc8fr_pkg::TIMEOUT_RESET;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            timer_reg      <= timer_next;
            timeout_reg    <= timeout_next;
            emit_idx_reg   <= emit_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload register of the output beat.
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // Frame store: written at the byte count, read with a registered port.
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            frame_mem[byte_count_reg[crc8fr_pkg::IDX_W-1:0]] <= in_data.rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

@@ rtl/core/crc8fr_ctrl.sv @@
// Controller of the frame receiver: input acceptance and payload emission sequencing.
`timescale 1ns / 1ps

module crc8fr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  crc8fr_pkg::dp_sts_t sts,
    output crc8fr_pkg::dp_cmd_t cmd
);

    crc8fr_pkg::ctrl_state_t state_reg, state_next;
    logic                    fire;

    // Input beats are taken only between frames' emission runs.
    assign in_ready = (state_reg == crc8fr_pkg::ST_IDLE) && sts.out_free;
    assign fire     = in_valid && in_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crc8fr_pkg::ST_IDLE:
            begin
                if (fire && !sts.is_tick && sts.frame_full && sts.crc_match)
                begin
                    state_next = crc8fr_pkg::ST_EMIT;
                end
            end
            crc8fr_pkg::ST_EMIT:
            begin
                if (sts.out_free && sts.emit_done)
                begin
                    state_next = crc8fr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crc8fr_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            crc8fr_pkg::ST_IDLE:
            begin
                if (fire && sts.is_tick)
                begin
                    if (sts.timer_active)
                    begin
                        cmd.dec_timer = 1'b1;
                        if (sts.timer_last)
                        begin
                            cmd.clear_frame = 1'b1;
                            cmd.post_single = 1'b1;
                            cmd.post_status = crc8fr_pkg::STATUS_TIMEOUT;
                        end
                    end
                end
                else if (fire)
                begin
                    cmd.reload_timer = 1'b1;
                    if (sts.frame_full)
                    begin
                        cmd.clear_frame = 1'b1;
                        if (sts.crc_match)
                        begin
                            cmd.start_emit = 1'b1;
                        end
                        else
                        begin
                            cmd.post_single = 1'b1;
                            cmd.post_status = crc8fr_pkg::STATUS_CRC_ERR;
                        end
                    end
                    else
                    begin
                        cmd.store_byte = 1'b1;
                    end
                end
            end
            crc8fr_pkg::ST_EMIT:
            begin
                cmd.emit_step = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crc8fr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // No input beat is taken while a payload run is being emitted.
    a_no_accept_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == crc8fr_pkg::ST_EMIT) |-> !in_ready)
        else $error("input accepted during payload emission");

    // A full frame with a matching CRC starts an emission run.
    a_good_frame_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !sts.is_tick && sts.frame_full && sts.crc_match)
        |=> (state_reg == crc8fr_pkg::ST_EMIT))
        else $error("good frame did not start emission");

    // The output register is loaded from one source at a time.
    a_single_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.post_single && (cmd.emit_step || cmd.start_emit)))
        else $error("output register loaded from two sources");

    // An emission step only happens when the output register can take it.
    a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> sts.out_free)
        else $error("emission step overwrote a waiting beat");

endmodule

@@ rtl/core/crc8_checked_frame_receiver_unit.sv @@
// A byte or tick beat is taken when in_ready is high; a single result is valid the next cycle.
// A good frame's final byte leads to its payload beats one per cycle while the output is not
// held back; each passes the registered read port of the frame store, then the output register.
// One input beat per cycle outside emission runs while no result beat waits; a run blocks
// input until its last payload beat is loaded, longer under output backpressure. Reset
// (rst_n low, async) clears count, CRC, timer and output valid, and sets the timeout to two ticks.
`timescale 1ns / 1ps

module crc8_checked_frame_receiver_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  crc8fr_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output crc8fr_pkg::out_item_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data
);

    crc8fr_pkg::dp_cmd_t cmd;
    crc8fr_pkg::dp_sts_t sts;

    // The timeout register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    crc8fr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    crc8fr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ dv/crc8fr_frame_checker.sv @@
// Checker for the CRC-8 frame receiver: predicts every result beat and compares it.
`timescale 1ns / 1ps

module crc8fr_frame_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  crc8fr_pkg::in_item_t  in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  crc8fr_pkg::out_item_t out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [7:0]            cfg_data,
    output int                    outstanding,
    output int                    mismatches
);

    localparam int PRINT_CAP = 40;

    // Shadow copy of the receiver state.
    logic [7:0]  payload_mem [crc8fr_pkg::PAYLOAD_LEN];
    int unsigned rx_count;
    logic [7:0]  crc_acc;
    logic [7:0]  idle_left;
    logic [7:0]  timeout_reg;

    // Result beats that the receiver still owes, oldest first.
    crc8fr_pkg::out_item_t owed_results [$];

    // Reflected CRC-8: fold the byte in, then shift out eight bits.
    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        r = acc ^ d;
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ crc8fr_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic crc8fr_pkg::out_item_t make_result(input logic [1:0] st,
                                                          input logic [7:0] d,
                                                          input logic [5:0] idx,
                                                          input logic lst);
        crc8fr_pkg::out_item_t r;
        r.status     = st;
        r.data_byte  = d;
        r.byte_index = idx;
        r.last       = lst;
        return r;
    endfunction

    // Every mismatch goes through here; printing is capped, counting is not.
    task automatic report_mismatch(input string what);
        mismatches = mismatches + 1;
        if (mismatches <= PRINT_CAP)
        begin
            $display("%0t ns: frame checker: %s", $realtime, what);
        end
    endtask

    // Work out the result beats caused by one accepted input beat.
    task automatic predict_beat(input crc8fr_pkg::in_item_t it);
        if (it.req_type == crc8fr_pkg::REQ_TICK)
        begin
            // A tick only matters while the inactivity timer is running.
            if (idle_left != 8'd0)
            begin
                idle_left = idle_left - 8'd1;
                if (idle_left == 8'd0)
                begin
                    rx_count = 0;
                    crc_acc  = 8'd0;
                    owed_results.push_back(make_result(crc8fr_pkg::STATUS_TIMEOUT, 8'd0, 6'd0,
                                                       1'b1));
                end
            end
        end
        else
        begin
            idle_left = timeout_reg;
            if (rx_count >= crc8fr_pkg::PAYLOAD_LEN)
            begin
                // This is the CRC byte closing the frame.
                if (it.rx_byte == crc_acc)
                begin
                    for (int i = 0; i < crc8fr_pkg::PAYLOAD_LEN; i++)
                    begin
                        owed_results.push_back(make_result(crc8fr_pkg::STATUS_DATA,
                                                           payload_mem[i], 6'(i),
                                                           (i == crc8fr_pkg::PAYLOAD_LEN - 1)));
                    end
                end
                else
                begin
                    owed_results.push_back(make_result(crc8fr_pkg::STATUS_CRC_ERR, 8'd0, 6'd0,
                                                       1'b1));
                end
                rx_count  = 0;
                crc_acc   = 8'd0;
                idle_left = 8'd0;
            end
            else
            begin
                payload_mem[rx_count] = it.rx_byte;
                crc_acc               = crc8_byte(crc_acc, it.rx_byte);
                rx_count              = rx_count + 1;
            end
        end
    endtask

    // Compare one accepted result beat with the oldest owed one.
    task automatic check_beat(input crc8fr_pkg::out_item_t got);
        crc8fr_pkg::out_item_t want;
        if (owed_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result status=%0d data=%02h index=%0d last=%0b",
                                      got.status, got.data_byte, got.byte_index, got.last));
        end
        else
        begin
            want = owed_results.pop_front();
            if (got !== want)
            begin
                report_mismatch($sformatf(
                    "got status=%0d data=%02h index=%0d last=%0b, want %0d %02h %0d %0b",
                    got.status, got.data_byte, got.byte_index, got.last,
                    want.status, want.data_byte, want.byte_index, want.last));
            end
        end
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count    = 0;
            crc_acc     = 8'd0;
            idle_left   = 8'd0;
            timeout_reg = crc8fr_pkg::TIMEOUT_RESET;
            mismatches  = 0;
            owed_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_beat(out_data);
            end
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                predict_beat(in_data);
            end
            outstanding <= owed_results.size();
        end
    end

endmodule

@@ dv/crc8_checked_frame_receiver_unit_test.sv @@
// Testbench top for the CRC-8 frame receiver: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module crc8_checked_frame_receiver_unit_test;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int UNITS_PER_PHASE = 3;
    localparam int PHASE_COUNT     = 5;
    localparam int LONG_TIMEOUT    = 16;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    crc8fr_pkg::in_item_t  in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    crc8fr_pkg::out_item_t out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [7:0]            cfg_data  = 8'd0;

    int outstanding;
    int mismatches;
    int burst_left  = 0;
    int cur_timeout = crc8fr_pkg::TIMEOUT_RESET;
    int idle_cycles = 0;

    // Receiver stall pattern state.
    int ready_mode  = 0;
    int ready_left  = 0;
    int ready_count = 0;

    crc8_checked_frame_receiver_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    crc8fr_frame_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The receiver picks a new stall style whenever the current one runs out.
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(16, 80);
        end
        ready_left  = ready_left - 1;
        ready_count = ready_count + 1;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((ready_count % 5) < 2);
        endcase
    end

    // Ends the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Frame byte CRC, used only to build good and bad frames.
    function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        r = acc ^ d;
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ crc8fr_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Offer one input beat; the sender works in bursts with random gaps.
    task automatic send_beat(input logic req, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        in_valid        <= 1'b1;
        in_data.req_type <= req;
        in_data.rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left = burst_left - 1;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(crc8fr_pkg::REQ_BYTE, b);
    endtask

    task automatic send_tick();
        send_beat(crc8fr_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Let every owed result arrive, then give the block time to settle.
    task automatic settle();
        in_valid   <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the timeout register while the block is idle.
    task automatic set_timeout(input int v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= 8'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        cur_timeout = v;
    endtask

    // Bring the byte count back to zero: one byte, then enough ticks to time out.
    task automatic realign();
        if (cur_timeout != 0)
        begin
            send_byte(8'($urandom_range(0, 255)));
            repeat (cur_timeout) send_tick();
        end
    endtask

    // One whole frame, good or with a corrupted CRC byte, optionally with ticks
    // between bytes that never let the timer run out.
    task automatic send_frame(input bit good, input bit with_ticks);
        logic [7:0] acc;
        logic [7:0] d;
        int         style;
        int         n;
        acc   = 8'd0;
        style = $urandom_range(0, 7);
        for (int i = 0; i < crc8fr_pkg::PAYLOAD_LEN; i++)
        begin
            case (style)
                0:       d = 8'hFF;
                1:       d = 8'h00;
                2:       d = i[0] ? 8'hAA : 8'h55;
                default: d = 8'($urandom_range(0, 255));
            endcase
            send_byte(d);
            acc = crc_step(acc, d);
            n = 0;
            if (with_ticks && cur_timeout > 1)
            begin
                n = $urandom_range(0, (cur_timeout > 4) ? 3 : cur_timeout - 1);
            end
            repeat (n) send_tick();
        end
        if (good)
        begin
            send_byte(acc);
        end
        else
        begin
            send_byte(acc ^ 8'($urandom_range(1, 255)));
        end
    endtask

    // A partial frame that is left to time out.
    task automatic send_stalled_frame();
        int k;
        if (cur_timeout != 0)
        begin
            k = $urandom_range(1, crc8fr_pkg::PAYLOAD_LEN);
            repeat (k) send_byte(8'($urandom_range(0, 255)));
            repeat (cur_timeout) send_tick();
        end
    endtask

    // Stray beats of either kind, then a return to frame alignment.
    task automatic send_noise();
        int k;
        k = $urandom_range(1, 4);
        repeat (k) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        realign();
    endtask

    initial
    begin
        logic [7:0] acc;
        int         timeout_plan [PHASE_COUNT];
        int         pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tick while the timer is idle: nothing should come out.
        send_tick();

        // Good frame of all-zero bytes; its CRC is zero as well.
        repeat (crc8fr_pkg::PAYLOAD_LEN + 1) send_byte(8'h00);

        // All-ones payload closed by an inverted CRC byte.
        acc = 8'd0;
        repeat (crc8fr_pkg::PAYLOAD_LEN)
        begin
            send_byte(8'hFF);
            acc = crc_step(acc, 8'hFF);
        end
        send_byte(~acc);

        // Timeout on the reset value of two ticks.
        send_byte(8'h80);
        send_byte(8'h01);
        send_tick();
        send_tick();

        // With a zero timeout a partial frame never times out.
        set_timeout(0);
        send_byte(8'h7F);
        send_tick();
        send_tick();

        // Random phases over several timeout settings, extremes included.
        // Every unit leaves the frame aligned, so only the first phase realigns.
        // Partial frames and noise cost a whole timeout of ticks, so long
        // timeouts get whole frames only.
        timeout_plan[0] = 1;
        timeout_plan[1] = 255;
        timeout_plan[2] = 2;
        timeout_plan[3] = $urandom_range(3, 16);
        timeout_plan[4] = $urandom_range(1, 255);
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_timeout(timeout_plan[p]);
            if (p == 0)
            begin
                realign();
            end
            for (int u = 0; u < UNITS_PER_PHASE; u++)
            begin
                pick = $urandom_range(0, (cur_timeout > LONG_TIMEOUT) ? 14 : 19);
                if (pick < 12)
                begin
                    send_frame(1'b1, 1'($urandom_range(0, 1)));
                end
                else if (pick < 15)
                begin
                    send_frame(1'b0, 1'($urandom_range(0, 1)));
                end
                else if (pick < 17)
                begin
                    send_stalled_frame();
                end
                else
                begin
                    send_noise();
                end
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
